FILE: sv/ljpf_pkg.sv
// Shared constants and codes for the Lennard-Jones pair force accumulator.
package ljpf_pkg;

   localparam int MAX_PARTICLES_DEF = 1024;

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 10;
   localparam int POS_W  = 32;
   localparam int ACC_W  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [FUNC_W-1:0] FUNC_PAIR    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RD_FORCE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RD_ENERGY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED  = 2'd3;

   localparam logic RESULT_FORCE  = 1'b0;
   localparam logic RESULT_ENERGY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_SQ  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_SQ   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WELL_DEPTH = 2'd3;

   localparam logic [31:0] BOX_LENGTH_RST = 32'd655360;
   localparam logic [47:0] CUTOFF_SQ_RST  = 48'd1048576;
   localparam logic [31:0] SIGMA_SQ_RST   = 32'd65536;
   localparam logic [31:0] WELL_DEPTH_RST = 32'd65536;

   localparam logic [63:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] UMAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

FILE: sv/lj_pair_force_accumulator.sv
// Lennard-Jones pair force accumulator with minimum-image wrap and force memory.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | func, particle_i/j, pos_i_*, pos_j_*
//  rsp     | out       | rsp_valid / rsp_stall   | result_kind, force_*, energy_total
//  csr     | in        | csr_we                  | csr_index, csr_wdata
//
// One item at a time. A pair item holds the input through the two radix-4 dividers
// (reciprocal of r squared, sigma squared over r squared), nine 64x64 products run
// as four 32x32 partial products each, and read-modify-write of the force memory. A
// skipped pair frees the input after separation, squaring and range check. After
// reset the force memory is cleared one entry a cycle with req_stall high. A readout
// waits while the result register is held by rsp_stall.
module lj_pair_force_accumulator #(
   parameter int MAX_PARTICLES = ljpf_pkg::MAX_PARTICLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ljpf_pkg::FUNC_W-1:0]          req_func,
   input  logic [ljpf_pkg::IDX_W-1:0]           req_particle_i,
   input  logic [ljpf_pkg::IDX_W-1:0]           req_particle_j,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_i_x,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_i_y,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_i_z,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_j_x,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_j_y,
   input  logic [ljpf_pkg::POS_W-1:0]           req_pos_j_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic signed [ljpf_pkg::ACC_W-1:0]    rsp_force_x,
   output logic signed [ljpf_pkg::ACC_W-1:0]    rsp_force_y,
   output logic signed [ljpf_pkg::ACC_W-1:0]    rsp_force_z,
   output logic signed [ljpf_pkg::ACC_W-1:0]    rsp_energy_total,
   input  logic                                 csr_we,
   input  logic [ljpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ljpf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ljpf_pkg::*;

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_SEP, S_SQ, S_CHK, S_DIV, S_MUL, S_MRES, S_DIFF,
      S_RDJ, S_WRJ, S_RDI, S_WRI, S_RDF, S_OUTF, S_OUTE
   } state_type;

   typedef enum logic [3:0] {
      OP_SS, OP_SSS, OP_SR12, OP_FA, OP_FMAG, OP_EN, OP_FX, OP_FY, OP_FZ
   } op_type;

   function automatic logic [63:0] ssat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SMIN64 : SMAX64;
      return s;
   endfunction

   function automatic logic [63:0] ssat_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? SMIN64 : SMAX64;
      return s;
   endfunction

   function automatic logic [63:0] to_signed(logic neg, logic [63:0] mag);
      if (neg) return mag[63] ? SMIN64 : 64'd0 - mag;
      return mag[63] ? SMAX64 : mag;
   endfunction

   // restoring divide step: {quotient bit, new remainder}
   function automatic logic [50:0] div_step(logic [49:0] rem, logic nb, logic [49:0] d);
      logic [50:0] t;
      t = {rem, nb};
      if (t >= {1'b0, d}) return {1'b1, 50'(t - {1'b0, d})};
      return {1'b0, t[49:0]};
   endfunction

   state_type state_ff;
   op_type    op_ff;

   logic [31:0] box_ff, sigma_ff, well_ff;
   logic [47:0] cutoff_ff;

   logic [FUNC_W-1:0] func_ff;
   logic [IDX_W-1:0]  pi_ff, pj_ff;
   logic [POS_W-1:0]  posi_ff [3];
   logic [POS_W-1:0]  posj_ff [3];

   logic        neg_ff [3];
   logic [32:0] mag_ff [3];
   logic [49:0] r2_ff;
   logic [4:0]  cnt_ff;

   logic [63:0] num_inv_ff, num_s_ff, q_inv_ff, q_s_ff;
   logic [49:0] rem_inv_ff, rem_s_ff;

   logic [127:0] acc_ff;
   logic [63:0]  t_ff, sr6_ff, sr12_ff, pa_ff, fmag_ff, en_ff, diff_ff, ediff_ff;
   logic         fneg_ff, eneg_ff;
   logic [63:0]  f_ff [3];
   logic [63:0]  energy_ff;

   logic [AW-1:0] clr_ff;
   logic [191:0]  force_mem [MAX_PARTICLES];
   logic [191:0]  mem_rd_ff;

   logic        rsp_valid_ff, rsp_kind_ff;
   logic [63:0] rsp_fx_ff, rsp_fy_ff, rsp_fz_ff, rsp_en_ff;

   // combinational
   logic        sep_neg [3];
   logic [32:0] sep_mag [3];
   logic [65:0] sq;
   logic [50:0] di1, di2, ds1, ds2;
   logic [63:0] ma, mb;
   logic [31:0] ma_h, mb_h;
   logic [63:0] pp;
   logic [1:0]  pp_sh;
   logic [127:0] acc_in;
   logic [63:0] mres;
   logic [1:0]  fk;
   logic [64:0] two_sum;
   logic [63:0] two;
   logic        rng_i, rng_j, slot_free, accept;
   logic        mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [191:0]  mem_wdata;
   logic [191:0]  rmw_in;
   logic [63:0]   kf, ke;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rng_i     = 32'(pi_ff) < 32'(MAX_PARTICLES);
   assign rng_j     = 32'(pj_ff) < 32'(MAX_PARTICLES);
   assign fk        = 2'(int'(op_ff) - int'(OP_FX));
   assign kf        = {11'b0, 37'({5'b0, well_ff} * 37'd24), 16'b0};
   assign ke        = {14'b0, well_ff, 18'b0};

   always_comb begin
      logic signed [34:0] d, len, twod;
      for (int k = 0; k < 3; k++) begin
         d    = 35'($signed({3'b0, posi_ff[k]}) - $signed({3'b0, posj_ff[k]}));
         len  = $signed({3'b0, box_ff});
         twod = d <<< 1;
         if (twod > len) d = d - len;
         else if (twod < -len) d = d + len;
         sep_neg[k] = d[34];
         sep_mag[k] = d[34] ? 33'(-d) : 33'(d);
      end
   end

   assign sq = 66'(mag_ff[cnt_ff[1:0]]) * 66'(mag_ff[cnt_ff[1:0]]);

   assign di1 = div_step(rem_inv_ff, num_inv_ff[63], r2_ff);
   assign di2 = div_step(di1[49:0], num_inv_ff[62], r2_ff);
   assign ds1 = div_step(rem_s_ff, num_s_ff[63], r2_ff);
   assign ds2 = div_step(ds1[49:0], num_s_ff[62], r2_ff);

   always_comb begin
      case (op_ff)
         OP_SS:   begin ma = q_s_ff;  mb = q_s_ff;   end
         OP_SSS:  begin ma = t_ff;    mb = q_s_ff;   end
         OP_SR12: begin ma = sr6_ff;  mb = sr6_ff;   end
         OP_FA:   begin ma = kf;      mb = diff_ff;  end
         OP_FMAG: begin ma = pa_ff;   mb = q_inv_ff; end
         OP_EN:   begin ma = ke;      mb = ediff_ff; end
         default: begin ma = fmag_ff; mb = {31'b0, mag_ff[fk]}; end
      endcase
      ma_h  = cnt_ff[0] ? ma[63:32] : ma[31:0];
      mb_h  = cnt_ff[1] ? mb[63:32] : mb[31:0];
      pp    = 64'(ma_h) * 64'(mb_h);
      pp_sh = {cnt_ff[0] & cnt_ff[1], cnt_ff[0] ^ cnt_ff[1]};
      acc_in = acc_ff + ({64'b0, pp} << {pp_sh, 5'b0});
      if (op_ff == OP_FX || op_ff == OP_FY || op_ff == OP_FZ)
         mres = (acc_ff[127:80] != '0) ? UMAX64 : acc_ff[79:16];
      else
         mres = (acc_ff[127:96] != '0) ? UMAX64 : acc_ff[95:32];
   end

   assign two_sum = {1'b0, sr12_ff} + {1'b0, sr12_ff};
   assign two     = two_sum[64] ? UMAX64 : two_sum[63:0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (state_ff == S_WRJ)
            rmw_in[64*k +: 64] = ssat_sub(mem_rd_ff[64*k +: 64], f_ff[k]);
         else
            rmw_in[64*k +: 64] = ssat_add(mem_rd_ff[64*k +: 64], f_ff[k]);
      end
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = AW'(pi_ff);
      mem_raddr = AW'(pi_ff);
      mem_wdata = '0;
      case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         S_RDJ: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pj_ff);
         end
         S_WRJ: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pj_ff);
            mem_wdata = rmw_in;
         end
         S_RDI, S_RDF: mem_re = 1'b1;
         S_WRI: begin
            mem_we    = 1'b1;
            mem_wdata = rmw_in;
         end
         S_OUTF: mem_we = slot_free && rng_i;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) force_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rd_ff <= force_mem[mem_raddr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff    <= BOX_LENGTH_RST;
         cutoff_ff <= CUTOFF_SQ_RST;
         sigma_ff  <= SIGMA_SQ_RST;
         well_ff   <= WELL_DEPTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOX_LENGTH: box_ff    <= csr_wdata[31:0];
            CSR_CUTOFF_SQ:  cutoff_ff <= csr_wdata;
            CSR_SIGMA_SQ:   sigma_ff  <= csr_wdata[31:0];
            CSR_WELL_DEPTH: well_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output states reload the result register themselves
         if (rsp_valid_ff && !rsp_stall && !(state_ff inside {S_OUTF, S_OUTE}))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(MAX_PARTICLES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  func_ff    <= req_func;
                  pi_ff      <= req_particle_i;
                  pj_ff      <= req_particle_j;
                  posi_ff[0] <= req_pos_i_x;
                  posi_ff[1] <= req_pos_i_y;
                  posi_ff[2] <= req_pos_i_z;
                  posj_ff[0] <= req_pos_j_x;
                  posj_ff[1] <= req_pos_j_y;
                  posj_ff[2] <= req_pos_j_z;
                  case (req_func)
                     FUNC_PAIR:      state_ff <= S_SEP;
                     FUNC_RD_FORCE:  state_ff <= S_RDF;
                     FUNC_RD_ENERGY: state_ff <= S_OUTE;
                     default:        state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SEP: begin
               for (int k = 0; k < 3; k++) begin
                  neg_ff[k] <= sep_neg[k];
                  mag_ff[k] <= sep_mag[k];
               end
               r2_ff    <= '0;
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               r2_ff  <= r2_ff + sq[65:16];
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd2) state_ff <= S_CHK;
            end
            S_CHK: begin
               num_inv_ff <= 64'h0001_0000_0000_0000;
               num_s_ff   <= {sigma_ff, 32'b0};
               rem_inv_ff <= '0;
               rem_s_ff   <= '0;
               cnt_ff     <= '0;
               if (!rng_i || !rng_j || r2_ff == '0 || r2_ff > {2'b0, cutoff_ff})
                  state_ff <= S_IDLE;
               else
                  state_ff <= S_DIV;
            end
            S_DIV: begin
               num_inv_ff <= num_inv_ff << 2;
               num_s_ff   <= num_s_ff << 2;
               rem_inv_ff <= di2[49:0];
               rem_s_ff   <= ds2[49:0];
               q_inv_ff   <= {q_inv_ff[61:0], di1[50], di2[50]};
               q_s_ff     <= {q_s_ff[61:0], ds1[50], ds2[50]};
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  op_ff    <= OP_SS;
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff[1:0] == 2'd3) state_ff <= S_MRES;
            end
            S_MRES: begin
               case (op_ff)
                  OP_SS:   t_ff    <= mres;
                  OP_SSS:  sr6_ff  <= mres;
                  OP_SR12: sr12_ff <= mres;
                  OP_FA:   pa_ff   <= mres;
                  OP_FMAG: fmag_ff <= mres;
                  OP_EN:   en_ff   <= to_signed(eneg_ff, mres);
                  default: f_ff[fk] <= to_signed(fneg_ff ^ neg_ff[fk], mres);
               endcase
               acc_ff <= '0;
               cnt_ff <= '0;
               if (op_ff != OP_FZ) op_ff <= op_type'(int'(op_ff) + 1);
               if (op_ff == OP_SR12) state_ff <= S_DIFF;
               else if (op_ff == OP_FZ) state_ff <= S_RDJ;
               else state_ff <= S_MUL;
            end
            S_DIFF: begin
               fneg_ff  <= two < sr6_ff;
               diff_ff  <= (two < sr6_ff) ? sr6_ff - two : two - sr6_ff;
               eneg_ff  <= sr12_ff < sr6_ff;
               ediff_ff <= (sr12_ff < sr6_ff) ? sr6_ff - sr12_ff : sr12_ff - sr6_ff;
               state_ff <= S_MUL;
            end
            S_RDJ: state_ff <= S_WRJ;
            // read of i waits for the write of j so that i == j sees the update
            S_WRJ: state_ff <= S_RDI;
            S_RDI: state_ff <= S_WRI;
            S_WRI: begin
               energy_ff <= ssat_add(energy_ff, en_ff);
               state_ff  <= S_IDLE;
            end
            S_RDF: state_ff <= S_OUTF;
            S_OUTF: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= RESULT_FORCE;
                  rsp_fx_ff    <= rng_i ? mem_rd_ff[63:0]    : '0;
                  rsp_fy_ff    <= rng_i ? mem_rd_ff[127:64]  : '0;
                  rsp_fz_ff    <= rng_i ? mem_rd_ff[191:128] : '0;
                  rsp_en_ff    <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            S_OUTE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= RESULT_ENERGY;
                  rsp_fx_ff    <= '0;
                  rsp_fy_ff    <= '0;
                  rsp_fz_ff    <= '0;
                  rsp_en_ff    <= energy_ff;
                  energy_ff    <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_force_x      = $signed(rsp_fx_ff);
   assign rsp_force_y      = $signed(rsp_fy_ff);
   assign rsp_force_z      = $signed(rsp_fz_ff);
   assign rsp_energy_total = $signed(rsp_en_ff);

endmodule

FILE: sv/ljpf_checker.sv
// Port-level checks for the pair force accumulator, bound to the top level.
module ljpf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [ljpf_pkg::FUNC_W-1:0]        req_func,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_result_kind,
   input logic signed [ljpf_pkg::ACC_W-1:0]  rsp_force_x,
   input logic signed [ljpf_pkg::ACC_W-1:0]  rsp_force_y,
   input logic signed [ljpf_pkg::ACC_W-1:0]  rsp_force_z,
   input logic signed [ljpf_pkg::ACC_W-1:0]  rsp_energy_total
);
   import ljpf_pkg::*;

   // memory clear keeps the input closed right after reset
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open during clear pass");

   a_pair_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FUNC_PAIR) |=> req_stall)
      else $error("pair item did not occupy the block");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_energy_zero_force: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == RESULT_ENERGY) |->
      (rsp_force_x == 0 && rsp_force_y == 0 && rsp_force_z == 0))
      else $error("energy item carries force");

   a_force_zero_energy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == RESULT_FORCE) |-> rsp_energy_total == 0)
      else $error("force item carries energy");

endmodule

bind lj_pair_force_accumulator ljpf_checker u_ljpf_checker (.*);
